FILE: hdl/clx_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and keyword table for the C subset lexer.
// No dependencies; used by every module of the block.
package clx_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_WORD = 2'd2,
    MODE_OP   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_NUMBER   = 3'd0,
    KIND_KEYWORD  = 3'd1,
    KIND_IDENT    = 3'd2,
    KIND_OPERATOR = 3'd3,
    KIND_SYMBOL   = 3'd4,
    KIND_UNKNOWN  = 3'd5
  } kind_t;

  typedef struct packed {
    logic [7:0]  c2;
    logic [7:0]  c1;
    logic [3:0]  kw;
    logic [15:0] len;
    logic [15:0] start;
    kind_t       kind;
  } token_t;

  typedef struct packed {
    logic [1:0] cnt;
    token_t     tok1;
    token_t     tok0;
  } bundle_t;

  localparam logic [7:0]  CH_EQ   = 8'h3D;
  localparam logic [7:0]  CH_US   = 8'h5F;
  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QFILL_W = $clog2(QDEPTH + 1);

  localparam int KW_NUM = 9;
  // int float char return if else while for void, first byte lowest
  localparam logic [63:0] KW_TEXT [KW_NUM] = '{
    64'h0000_0000_0074_6E69,
    64'h0000_0074_616F_6C66,
    64'h0000_0000_7261_6863,
    64'h0000_6E72_7574_6572,
    64'h0000_0000_0000_6669,
    64'h0000_0000_6573_6C65,
    64'h0000_0065_6C69_6877,
    64'h0000_0000_0072_6F66,
    64'h0000_0000_6469_6F76
  };
  localparam logic [15:0] KW_LEN [KW_NUM] = '{
    16'd3, 16'd5, 16'd4, 16'd6, 16'd2, 16'd4, 16'd5, 16'd3, 16'd4
  };

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_opch(input logic [7:0] b);
    return b inside {8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D, 8'h21, 8'h3C, 8'h3E};
  endfunction

  function automatic logic is_symch(input logic [7:0] b);
    return b inside {8'h3B, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h2C};
  endfunction

  // hit flag in bit 4, index below
  function automatic logic [4:0] kw_lookup(input logic [63:0] p, input logic [15:0] c);
    logic [4:0] r;
    r = '0;
    for (int k = 0; k < KW_NUM; k++) begin
      if (!r[4] && c == KW_LEN[k] && p == KW_TEXT[k]) begin
        r = {1'b1, 4'(k)};
      end
    end
    return r;
  endfunction

  function automatic token_t make_token(input kind_t kind, input logic [15:0] start,
                                        input logic [15:0] len, input logic [3:0] kw,
                                        input logic [7:0] c1, input logic [7:0] c2);
    token_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = len;
    t.kw    = kw;
    t.c1    = c1;
    t.c2    = c2;
    return t;
  endfunction

  // token for whatever is open in mode m
  function automatic token_t flush_token(input mode_t m, input logic [15:0] s,
                                         input logic [15:0] c, input logic [63:0] p,
                                         input logic [7:0] op);
    token_t     t;
    logic [4:0] kw;
    kw = kw_lookup(p, c);
    t  = make_token(KIND_NUMBER, s, c, 4'd0, 8'd0, 8'd0);
    case (m)
      MODE_WORD: begin
        if (kw[4]) begin
          t.kind = KIND_KEYWORD;
          t.kw   = kw[3:0];
        end else begin
          t.kind = KIND_IDENT;
        end
      end
      MODE_OP: begin
        t.kind = KIND_OPERATOR;
        t.len  = 16'd1;
        t.c1   = op;
      end
      default: ;
    endcase
    return t;
  endfunction

endpackage

FILE: hdl/clx_front.sv
`timescale 1ns / 1ps
// Front end: accepts source bytes, tracks the open token and classifies
// each byte into a bundle of up to two tokens. Depends on clx_pkg.
module clx_front #(
  parameter int POSITION_BITS = 16,
  parameter int KEYWORD_BYTES = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             in_final,
  input  logic             q_full,
  output logic             push,
  output clx_pkg::bundle_t bundle
);
  import clx_pkg::*;

  localparam int PFX_W = 8 * KEYWORD_BYTES;

  mode_t                    mode, mode_mid, mode_next;
  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [POSITION_BITS-1:0] tstart, tstart_next;
  logic [15:0]              tcount, tcount_next;
  logic [PFX_W-1:0]         prefix, prefix_next;
  logic [7:0]               pend, pend_next;
  logic                     fire, used;
  logic                     v_old, v_byte, v_fin;
  token_t                   t_old, t_byte, t_fin;

  function automatic logic [15:0] to16(input logic [POSITION_BITS-1:0] v);
    logic [POSITION_BITS+15:0] w;
    w = {16'b0, v};
    return w[15:0];
  endfunction

  function automatic logic [63:0] to64(input logic [PFX_W-1:0] v);
    logic [PFX_W+63:0] w;
    w = {64'b0, v};
    return w[63:0];
  endfunction

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  always_comb begin
    mode_mid    = mode;
    tstart_next = tstart;
    tcount_next = tcount;
    prefix_next = prefix;
    pend_next   = pend;
    used        = 1'b0;
    v_old       = 1'b0;
    v_byte      = 1'b0;
    t_old       = flush_token(mode, to16(tstart), tcount, to64(prefix), pend);
    t_byte      = make_token(KIND_SYMBOL, to16(pos), 16'd1, 4'd0, in_byte, 8'd0);

    case (mode)
      MODE_OP: begin
        v_old    = 1'b1;
        mode_mid = MODE_IDLE;
        if (in_byte == CH_EQ) begin
          t_old = make_token(KIND_OPERATOR, to16(tstart), 16'd2, 4'd0, pend, CH_EQ);
          used  = 1'b1;
        end
      end
      MODE_NUM: begin
        if (is_digit(in_byte)) begin
          tcount_next = (tcount == LEN_MAX) ? tcount : tcount + 16'd1;
          used        = 1'b1;
        end else begin
          v_old    = 1'b1;
          mode_mid = MODE_IDLE;
        end
      end
      MODE_WORD: begin
        if (is_alpha(in_byte) || is_digit(in_byte) || in_byte == CH_US) begin
          for (int k = 0; k < KEYWORD_BYTES; k++) begin
            if (tcount == 16'(k)) begin
              prefix_next[8*k +: 8] = in_byte;
            end
          end
          tcount_next = (tcount == LEN_MAX) ? tcount : tcount + 16'd1;
          used        = 1'b1;
        end else begin
          v_old    = 1'b1;
          mode_mid = MODE_IDLE;
        end
      end
      default: ;
    endcase

    if (!used) begin
      if (is_space(in_byte)) begin
      end else if (is_digit(in_byte)) begin
        mode_mid    = MODE_NUM;
        tstart_next = pos;
        tcount_next = 16'd1;
      end else if (is_alpha(in_byte) || in_byte == CH_US) begin
        mode_mid    = MODE_WORD;
        tstart_next = pos;
        tcount_next = 16'd1;
        prefix_next = PFX_W'(in_byte);
      end else if (is_opch(in_byte)) begin
        mode_mid    = MODE_OP;
        tstart_next = pos;
        tcount_next = 16'd1;
        pend_next   = in_byte;
      end else if (is_symch(in_byte)) begin
        v_byte = 1'b1;
      end else begin
        v_byte      = 1'b1;
        t_byte.kind = KIND_UNKNOWN;
      end
    end

    t_fin     = flush_token(mode_mid, to16(tstart_next), tcount_next, to64(prefix_next),
                            pend_next);
    v_fin     = in_final && (mode_mid != MODE_IDLE);
    mode_next = in_final ? MODE_IDLE : mode_mid;
    pos_next  = in_final ? '0 : pos + 1'b1;

    bundle.cnt  = 2'(v_old) + 2'(v_byte || v_fin);
    bundle.tok0 = v_old ? t_old : (v_byte ? t_byte : t_fin);
    bundle.tok1 = v_byte ? t_byte : t_fin;
    push        = fire && (v_old || v_byte || v_fin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
    end else if (fire) begin
      mode <= mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      tstart <= '0;
      tcount <= '0;
      prefix <= '0;
      pend   <= '0;
    end else if (fire) begin
      pos    <= pos_next;
      tstart <= tstart_next;
      tcount <= tcount_next;
      prefix <= prefix_next;
      pend   <= pend_next;
    end
  end

endmodule

FILE: hdl/clx_queue.sv
`timescale 1ns / 1ps
// Short queue of token bundles between the front and back ends.
// Depends on clx_pkg.
module clx_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  clx_pkg::bundle_t wdata,
  output logic             full,
  input  logic             pop,
  output clx_pkg::bundle_t rdata,
  output logic             not_empty
);
  import clx_pkg::*;

  bundle_t             mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QFILL_W-1:0]  fill;

  assign full      = (fill == QFILL_W'(QDEPTH));
  assign not_empty = (fill != '0);
  assign rdata     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("bundle pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("bundle popped from empty queue");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= QFILL_W'(QDEPTH))
    else $error("queue fill out of range");
  a_bundle_cnt: assert property (@(posedge clk) disable iff (rst)
    push |-> (wdata.cnt == 2'd1 || wdata.cnt == 2'd2))
    else $error("pushed bundle holds no token or too many");
`endif

endmodule

FILE: hdl/clx_back.sv
`timescale 1ns / 1ps
// Back end: unpacks queued bundles one token per cycle, while out_ready does not stall
// it, into the output register. Depends on clx_pkg.
module clx_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  clx_pkg::bundle_t q_head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [55:0]      out_data,
  output logic             out_last
);
  import clx_pkg::*;

  logic   sel, sel_next;
  logic   load, last;
  token_t tok;

  assign tok      = sel ? q_head.tok1 : q_head.tok0;
  assign last     = sel || (q_head.cnt == 2'd1);
  assign load     = q_valid && (!out_valid || out_ready);
  assign pop      = load && last;
  assign sel_next = load ? !last : sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      sel <= sel_next;
      if (!out_valid || out_ready) begin
        out_valid <= q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= {1'b0, tok};
      out_last <= last;
    end
  end

endmodule

FILE: hdl/c_subset_lexer.sv
`timescale 1ns / 1ps
// C subset lexer top level: front end, bundle queue and back end.
// Path: the bundle of a byte that closes a token is written into the queue, then its
// first token is loaded into the output register, a second one once that is free.
// Throughput: one byte per cycle while the queue is not full; one token per cycle out
// of the output register unless stalled; a four-bundle queue absorbs two-token bytes.
// Reset (synchronous, rst high): scanner idle at offset zero, queue empty.
module c_subset_lexer #(
  parameter int POSITION_BITS = 16,
  parameter int KEYWORD_BYTES = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // source_byte
  input  logic        s_axis_tlast,  // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // token_kind, start_position, token_length,
                                     // keyword_index, first_char, second_char, pad
  output logic        m_axis_tlast   // run_last
);
  import clx_pkg::*;

  logic    q_full, q_push, q_pop, q_valid;
  bundle_t q_wdata, q_rdata;

  clx_front #(
    .POSITION_BITS(POSITION_BITS),
    .KEYWORD_BYTES(KEYWORD_BYTES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .in_byte (s_axis_tdata),
    .in_final(s_axis_tlast),
    .q_full  (q_full),
    .push    (q_push),
    .bundle  (q_wdata)
  );

  clx_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .rdata    (q_rdata),
    .not_empty(q_valid)
  );

  clx_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_rdata),
    .pop      (q_pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (m_axis_tdata),
    .out_last (m_axis_tlast)
  );

endmodule

FILE: tb/token_checker.sv
`timescale 1ns / 1ps
// Token checker for the C subset lexer: watches the byte and token streams, predicts
// every token from the accepted source bytes and compares results in arrival order.
// Depends on clx_pkg for the scan mode, token kind codes and character constants.
module token_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // source_byte
  input  logic        s_axis_tlast,   // final_byte
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,   // token_kind, start_position, token_length,
                                      // keyword_index, first_char, second_char, pad
  input  logic        m_axis_tlast,   // run_last
  output int          fail_count,
  output int          tokens_waiting,
  output int          tokens_checked
);
  import clx_pkg::*;

  typedef struct {
    kind_t       kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [3:0]  kw;
    logic [7:0]  c1;
    logic [7:0]  c2;
    logic        last;
  } lex_token_t;

  localparam int PREFIX_BYTES = 6;

  string kw_spelling [9] = '{"int", "float", "char", "return", "if", "else", "while",
                             "for", "void"};

  mode_t                      scan;
  logic [15:0]                next_pos;
  logic [15:0]                tok_start;
  logic [15:0]                tok_len;
  logic [8*PREFIX_BYTES-1:0]  prefix;
  logic [7:0]                 pend_op;
  lex_token_t                 step_tokens [$];
  lex_token_t                 expected_tokens [$];
  lex_token_t                 want;
  int                         fails;
  int                         checked;

  function automatic logic ch_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic ch_letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic ch_blank(input logic [7:0] b);
    return b == " " || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic ch_oper(input logic [7:0] b);
    case (b)
      "+", "-", "*", "/", "=", "!", "<", ">": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic ch_punct(input logic [7:0] b);
    case (b)
      ";", "(", ")", "{", "}", "[", "]", ",": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic lex_token_t tok(input kind_t k, input logic [15:0] s,
                                     input logic [15:0] l, input logic [3:0] kw,
                                     input logic [7:0] c1, input logic [7:0] c2);
    lex_token_t t;
    t.kind  = k;
    t.start = s;
    t.len   = l;
    t.kw    = kw;
    t.c1    = c1;
    t.c2    = c2;
    t.last  = 1'b0;
    return t;
  endfunction

  function automatic void add_step(input lex_token_t t);
    step_tokens.insert(step_tokens.size(), t);
  endfunction

  function automatic int keyword_of(input logic [8*PREFIX_BYTES-1:0] p,
                                    input logic [15:0] n);
    logic [8*PREFIX_BYTES-1:0] spelled;
    if (n > PREFIX_BYTES) return -1;
    for (int k = 0; k < 9; k++) begin
      if (kw_spelling[k].len() == n) begin
        spelled = '0;
        for (int j = 0; j < kw_spelling[k].len(); j++) spelled[8*j +: 8] = kw_spelling[k][j];
        if (spelled == p) return k;
      end
    end
    return -1;
  endfunction

  task automatic close_open();
    int kw;
    case (scan)
      MODE_NUM: add_step(tok(KIND_NUMBER, tok_start, tok_len, 4'd0, 8'd0, 8'd0));
      MODE_WORD: begin
        kw = keyword_of(prefix, tok_len);
        if (kw >= 0) begin
          add_step(tok(KIND_KEYWORD, tok_start, tok_len, 4'(kw), 8'd0, 8'd0));
        end else begin
          add_step(tok(KIND_IDENT, tok_start, tok_len, 4'd0, 8'd0, 8'd0));
        end
      end
      MODE_OP: add_step(tok(KIND_OPERATOR, tok_start, 16'd1, 4'd0, pend_op, 8'd0));
      default: ;
    endcase
    scan = MODE_IDLE;
  endtask

  task automatic lex_byte(input logic [7:0] b, input logic fin);
    logic        used;
    logic [15:0] here;
    lex_token_t  t;
    step_tokens.delete();
    here = next_pos;
    used = 1'b0;
    case (scan)
      MODE_OP: begin
        if (b == CH_EQ) begin
          add_step(tok(KIND_OPERATOR, tok_start, 16'd2, 4'd0, pend_op, CH_EQ));
          scan = MODE_IDLE;
          used = 1'b1;
        end else begin
          close_open();
        end
      end
      MODE_NUM: begin
        if (ch_digit(b)) begin
          if (tok_len != LEN_MAX) tok_len = tok_len + 16'd1;
          used = 1'b1;
        end else begin
          close_open();
        end
      end
      MODE_WORD: begin
        if (ch_letter(b) || ch_digit(b) || b == CH_US) begin
          if (tok_len < PREFIX_BYTES) prefix[8*tok_len +: 8] = b;
          if (tok_len != LEN_MAX) tok_len = tok_len + 16'd1;
          used = 1'b1;
        end else begin
          close_open();
        end
      end
      default: ;
    endcase
    if (!used && !ch_blank(b)) begin
      if (ch_digit(b)) begin
        scan      = MODE_NUM;
        tok_start = here;
        tok_len   = 16'd1;
      end else if (ch_letter(b) || b == CH_US) begin
        scan        = MODE_WORD;
        tok_start   = here;
        tok_len     = 16'd1;
        prefix      = '0;
        prefix[7:0] = b;
      end else if (ch_oper(b)) begin
        scan      = MODE_OP;
        tok_start = here;
        tok_len   = 16'd1;
        pend_op   = b;
      end else if (ch_punct(b)) begin
        add_step(tok(KIND_SYMBOL, here, 16'd1, 4'd0, b, 8'd0));
      end else begin
        add_step(tok(KIND_UNKNOWN, here, 16'd1, 4'd0, b, 8'd0));
      end
    end
    if (fin) begin
      close_open();
      next_pos = '0;
    end else begin
      next_pos = here + 16'd1;
    end
    foreach (step_tokens[i]) begin
      t      = step_tokens[i];
      t.last = (i == step_tokens.size() - 1);
      expected_tokens.insert(expected_tokens.size(), t);
    end
  endtask

  task automatic note_fail(input string what);
    fails++;
    if (fails <= 10) $display("[%0t] %s", $time, what);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      scan      = MODE_IDLE;
      next_pos  = '0;
      tok_start = '0;
      tok_len   = '0;
      prefix    = '0;
      pend_op   = '0;
      fails     = 0;
      checked   = 0;
      expected_tokens.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_tokens.size() == 0) begin
          note_fail($sformatf("token with none expected: tdata %h last %b",
                              m_axis_tdata, m_axis_tlast));
        end else begin
          want = expected_tokens.pop_front();
          checked++;
          if (m_axis_tdata[2:0] != want.kind || m_axis_tdata[18:3] != want.start ||
              m_axis_tdata[34:19] != want.len || m_axis_tdata[38:35] != want.kw ||
              m_axis_tdata[46:39] != want.c1 || m_axis_tdata[54:47] != want.c2 ||
              m_axis_tdata[55] != 1'b0 || m_axis_tlast != want.last) begin
            note_fail($sformatf({"token %0d: expected kind %0d start %0d len %0d kw %0d ",
                                 "c1 %h c2 %h last %b; got kind %0d start %0d len %0d ",
                                 "kw %0d c1 %h c2 %h last %b pad %b"},
                                checked, want.kind, want.start, want.len, want.kw,
                                want.c1, want.c2, want.last, m_axis_tdata[2:0],
                                m_axis_tdata[18:3], m_axis_tdata[34:19],
                                m_axis_tdata[38:35], m_axis_tdata[46:39],
                                m_axis_tdata[54:47], m_axis_tlast, m_axis_tdata[55]));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) lex_byte(s_axis_tdata, s_axis_tlast);
    end
    fail_count     <= fails;
    tokens_waiting <= expected_tokens.size();
    tokens_checked <= checked;
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the C subset lexer: clock, reset, source text stimulus, token
// sink with back-pressure, watchdog and verdict. Depends on clx_pkg, c_subset_lexer
// and token_checker.
module tb_top;
  import clx_pkg::*;

  localparam int IDLE_LIMIT     = 2000;
  localparam int ITEM_TARGET    = 220;
  localparam int SQUEEZE_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;  // source_byte
  logic        s_axis_tlast = 1'b0;  // final_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;         // token_kind, start_position, token_length,
                                     // keyword_index, first_char, second_char, pad
  logic        m_axis_tlast;         // run_last

  int fail_count;
  int tokens_waiting;
  int tokens_checked;
  int idle_cycles = 0;
  int bytes_sent = 0;
  int kw_turn = 0;
  bit calm = 1'b0;
  bit squeeze_req = 1'b0;

  logic [7:0] text_buf [$];
  string      reserved_words [9] = '{"int", "float", "char", "return", "if", "else",
                                     "while", "for", "void"};
  string      op_set = "+-*/=!<>";
  string      sym_set = ";(){}[],";
  logic [7:0] blank_set [6] = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  c_subset_lexer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  token_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tlast   (s_axis_tlast),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .fail_count     (fail_count),
    .tokens_waiting (tokens_waiting),
    .tokens_checked (tokens_checked)
  );

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("no item moved for %0d cycles, stopping", idle_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : token_sink
    int hold;
    int r;
    hold = 0;
    forever begin
      @(negedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        m_axis_tready <= 1'b0;
        hold = SQUEEZE_CYCLES;
      end else if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          m_axis_tready <= 1'b1;
          hold = $urandom_range(0, 8);
        end else if (r < 90) begin
          m_axis_tready <= 1'b0;
          hold = $urandom_range(0, 3);
        end else if (r < 97) begin
          m_axis_tready <= 1'b0;
          hold = $urandom_range(5, 40);
        end else begin
          m_axis_tready <= 1'b1;
          hold = $urandom_range(30, 80);
        end
      end
    end
  end

  function automatic int sender_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [7:0] rand_word_ch();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return CH_US;
  endfunction

  function automatic logic [7:0] rand_lead();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return CH_US;
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    text_buf.insert(text_buf.size(), b);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = sender_gap();
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // flag the last byte of the buffered text as final
  task automatic send_text();
    foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic make_random_text();
    int r;
    calm = ($urandom_range(0, 3) == 0);
    repeat ($urandom_range(1, 8)) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        add_str(reserved_words[kw_turn < 9 ? kw_turn : $urandom_range(0, 8)]);
        kw_turn++;
        if ($urandom_range(0, 4) == 0) add_byte(rand_word_ch());
      end else if (r < 35) begin
        add_byte(rand_lead());
        repeat ($urandom_range(0, 8)) add_byte(rand_word_ch());
      end else if (r < 50) begin
        repeat ($urandom_range(1, 5)) add_byte(8'("0" + $urandom_range(0, 9)));
      end else if (r < 65) begin
        add_byte(op_set[$urandom_range(0, 7)]);
        if ($urandom_range(0, 9) < 4) add_byte(CH_EQ);
      end else if (r < 75) begin
        add_byte(sym_set[$urandom_range(0, 7)]);
      end else if (r < 90) begin
        repeat ($urandom_range(1, 2)) add_byte(blank_set[$urandom_range(0, 5)]);
      end else begin
        add_byte(8'($urandom_range(0, 255)));
      end
    end
    send_text();
  endtask

  initial begin : stimulus
    bit squeezed;
    squeezed = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_str("a+=b;");
    send_text();
    text_buf = '{8'h00, 8'hFF, 8'h80, "7"};
    send_text();
    add_str("+-*/=!<>=");
    send_text();
    add_str(";(){}[],");
    send_text();
    text_buf = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20};
    add_str("_z9");
    send_text();
    add_str("returns_x");
    send_text();
    add_str("-");
    send_text();
    add_str("12 ");
    send_text();

    while (bytes_sent < ITEM_TARGET) begin
      if (!squeezed && bytes_sent > ITEM_TARGET / 2) begin
        squeezed    = 1'b1;
        squeeze_req = 1'b1;
        calm        = 1'b1;
        repeat (20) begin
          add_byte(rand_lead());
          add_byte(sym_set[$urandom_range(0, 7)]);
        end
        send_text();
      end
      make_random_text();
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (tokens_waiting != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Run covered %0d source bytes: directed texts for every byte class and",
             bytes_sent);
    $display("random texts under back-pressure with one long stall; %0d tokens compared",
             tokens_checked);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
